// File: hw/rtl/hpf_pkg.sv
// hpf_pkg: shared types and constants for the histogram peak finder
// no dependencies; imported by histogram_peak_finder
package hpf_pkg;

   // fixed field widths
   localparam int PIXEL_W      = 8;
   localparam int RADIUS_W     = 6;
   localparam int MIN_HEIGHT_W = 20;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 20;

   // parameter defaults
   localparam int DEF_NUM_BINS    = 256;
   localparam int DEF_COUNT_WIDTH = 20;
   localparam int DEF_MAX_PEAKS   = 64;

   // register reset values
   localparam logic [RADIUS_W-1:0]     RADIUS_RESET     = RADIUS_W'(10);
   localparam logic [MIN_HEIGHT_W-1:0] MIN_HEIGHT_RESET = MIN_HEIGHT_W'(100);

   // run length that a peak may fall short of the radius
   localparam logic [RADIUS_W-1:0] RUN_SLACK = RADIUS_W'(3);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_RADIUS   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PEAK_HEIGHT = 1'b1;

   // input opcodes
   localparam logic OP_PIXEL  = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   // sequencer states
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_PIX  = 7'b0000010,
      ST_NBR  = 7'b0000100,
      ST_CMP  = 7'b0001000,
      ST_RD   = 7'b0010000,
      ST_LOAD = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

endpackage

// File: hw/rtl/histogram_peak_finder.sv
// histogram_peak_finder: histogram build and peak scan under one sequencer
// depends on hpf_pkg
//
// A pixel beat makes one memory read of its bin, then the saturating
// write back. A finish beat walks bins 1 to NUM_BINS-2 over the two read
// ports of the histogram memory: a bin whose count does not exceed
// min_peak_height is skipped, a taller bin is compared with its neighbors
// at growing distances (at most max(1, window_radius-3)). Each report beat
// then passes ST_RD, ST_LOAD and ST_OUT and waits out any output stall; an
// empty report is a single beat. The block stalls its input for the whole
// time. The histogram is cleared at the end of the scan through per-bin
// valid flags, so no clearing pass follows reset.
module histogram_peak_finder
   import hpf_pkg::*;
#(
   parameter int NUM_BINS    = DEF_NUM_BINS,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
   parameter int MAX_PEAKS   = DEF_MAX_PEAKS
) (
   input  logic                   clock,
   input  logic                   reset,
   // input channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_op,
   input  logic [PIXEL_W-1:0]     req_pixel,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_peak_valid,
   output logic [PIXEL_W-1:0]     rsp_peak_bin,
   output logic [COUNT_WIDTH-1:0] rsp_peak_count,
   output logic                   rsp_peaks_dropped,
   output logic                   rsp_last,
   // configuration
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int BIN_W  = $clog2(NUM_BINS);
   localparam int AW     = ((BIN_W > RADIUS_W) ? BIN_W : RADIUS_W) + 1;
   localparam int CMP_W  = (COUNT_WIDTH > MIN_HEIGHT_W) ? COUNT_WIDTH : MIN_HEIGHT_W;
   localparam int PK_W   = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
   localparam int KEPT_W = $clog2(MAX_PEAKS + 1);
   localparam int PE_W   = BIN_W + COUNT_WIDTH;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [BIN_W-1:0]       LAST_BIN  = BIN_W'(NUM_BINS - 2);
   localparam logic [BIN_W-1:0]       FIRST_BIN = BIN_W'(1);
   localparam logic [AW-1:0]          TOP_BIN   = AW'(NUM_BINS - 1);
   localparam logic [KEPT_W-1:0]      KEPT_FULL = KEPT_W'(MAX_PEAKS);

   // registers
   state_type                state_ff, state_in;
   logic [RADIUS_W-1:0]      radius_ff, radius_in;
   logic [MIN_HEIGHT_W-1:0]  min_height_ff, min_height_in;
   logic [BIN_W-1:0]         idx_ff, idx_in;
   logic [RADIUS_W-1:0]      dist_ff, dist_in;
   logic [COUNT_WIDTH-1:0]   cand_ff, cand_in;
   logic [KEPT_W-1:0]        kept_ff, kept_in;
   logic                     dropped_ff, dropped_in;
   logic [PK_W-1:0]          ptr_ff, ptr_in;
   logic [BIN_W-1:0]         pix_ff, pix_in;
   logic [NUM_BINS-1:0]      bin_vld_ff, bin_vld_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     out_pv_ff, out_pv_in;
   logic [PIXEL_W-1:0]       out_bin_ff, out_bin_in;
   logic [COUNT_WIDTH-1:0]   out_cnt_ff, out_cnt_in;
   logic                     out_drop_ff, out_drop_in;
   logic                     out_last_ff, out_last_in;

   // memory read side
   logic [COUNT_WIDTH-1:0]   rd_a_ff, rd_b_ff;
   logic                     rv_a_ff, rv_b_ff;
   logic                     oob_a_ff, oob_b_ff;
   logic                     oob_a_in, oob_b_in;
   logic [BIN_W-1:0]         addr_a, addr_b;
   logic [PE_W-1:0]          pk_rd_ff;

   // memory write side
   logic                     hist_we;
   logic [COUNT_WIDTH-1:0]   hist_wd;
   logic                     pk_we;
   logic [PE_W-1:0]          pk_wd;

   logic [COUNT_WIDTH-1:0]   hist_mem [NUM_BINS];
   logic [PE_W-1:0]          peak_mem [MAX_PEAKS];

   // datapath helpers
   logic [COUNT_WIDTH-1:0]   val_a, val_b;
   logic [RADIUS_W-1:0]      need;
   logic [RADIUS_W-1:0]      dist_iss;
   logic [AW-1:0]            left_ext, right_ext;
   logic [BIN_W-1:0]         idx_next;
   logic                     in_accept, out_accept;
   logic                     tall, ok_l, ok_r, last_idx;

   assign in_accept  = req_valid && !req_stall;
   assign out_accept = rsp_valid_ff && !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;

   // bins with no valid flag read as zero, as do neighbors off either end
   assign val_a = (rv_a_ff && !oob_a_ff) ? rd_a_ff : '0;
   assign val_b = (rv_b_ff && !oob_b_ff) ? rd_b_ff : '0;

   // distance the run must reach
   assign need = (radius_ff > RUN_SLACK) ? (radius_ff - RUN_SLACK) : '0;

   // neighbor addresses for the distance being issued
   assign left_ext  = AW'(idx_ff) - AW'(dist_iss);
   assign right_ext = AW'(idx_ff) + AW'(dist_iss);
   assign idx_next  = idx_ff + BIN_W'(1);
   assign last_idx  = (idx_ff == LAST_BIN);

   // candidate tests
   assign tall = CMP_W'(val_a) > CMP_W'(min_height_ff);
   assign ok_l = (cand_ff > val_a) || ((dist_ff != RADIUS_W'(1)) && (cand_ff == val_a));
   assign ok_r = (cand_ff > val_b) || ((dist_ff != RADIUS_W'(1)) && (cand_ff == val_b));

   // configuration writes
   always_comb begin
      radius_in     = radius_ff;
      min_height_in = min_height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WINDOW_RADIUS:   radius_in     = csr_wdata[RADIUS_W-1:0];
            CSR_MIN_PEAK_HEIGHT: min_height_in = csr_wdata[MIN_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      dist_in      = dist_ff;
      cand_in      = cand_ff;
      kept_in      = kept_ff;
      dropped_in   = dropped_ff;
      ptr_in       = ptr_ff;
      pix_in       = pix_ff;
      bin_vld_in   = bin_vld_ff;
      rsp_valid_in = rsp_valid_ff;
      out_pv_in    = out_pv_ff;
      out_bin_in   = out_bin_ff;
      out_cnt_in   = out_cnt_ff;
      out_drop_in  = out_drop_ff;
      out_last_in  = out_last_ff;
      dist_iss     = RADIUS_W'(1);
      addr_a       = idx_next;
      addr_b       = idx_next;
      oob_a_in     = 1'b0;
      oob_b_in     = 1'b0;
      hist_we      = 1'b0;
      hist_wd      = (val_a == COUNT_MAX) ? val_a : (val_a + COUNT_WIDTH'(1));
      pk_we        = 1'b0;
      pk_wd        = {idx_ff, cand_ff};

      case (state_ff)
         ST_IDLE: begin
            if (in_accept) begin
               if (req_op == OP_FINISH) begin
                  // start the scan with a read of the first candidate
                  addr_a     = FIRST_BIN;
                  idx_in     = FIRST_BIN;
                  kept_in    = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_NBR;
               end else if ((PIXEL_W+1)'(req_pixel) < (PIXEL_W+1)'(NUM_BINS)) begin
                  addr_a   = req_pixel[BIN_W-1:0];
                  pix_in   = req_pixel[BIN_W-1:0];
                  state_in = ST_PIX;
               end
            end
         end

         ST_PIX: begin
            // saturating increment written back
            hist_we            = 1'b1;
            bin_vld_in[pix_ff] = 1'b1;
            state_in           = ST_IDLE;
         end

         ST_NBR: begin
            // center count in hand: issue the direct neighbors or skip
            if (tall) begin
               cand_in  = val_a;
               dist_iss = RADIUS_W'(1);
               dist_in  = RADIUS_W'(1);
               addr_a   = left_ext[BIN_W-1:0];
               addr_b   = right_ext[BIN_W-1:0];
               oob_a_in = left_ext[AW-1];
               oob_b_in = right_ext > TOP_BIN;
               state_in = ST_CMP;
            end else if (last_idx) begin
               bin_vld_in = '0;
               ptr_in     = '0;
               state_in   = ST_RD;
            end else begin
               idx_in = idx_next;
            end
         end

         ST_CMP: begin
            if (ok_l && ok_r && (dist_ff < need)) begin
               // run continues one step further out
               dist_iss = dist_ff + RADIUS_W'(1);
               dist_in  = dist_iss;
               addr_a   = left_ext[BIN_W-1:0];
               addr_b   = right_ext[BIN_W-1:0];
               oob_a_in = left_ext[AW-1];
               oob_b_in = right_ext > TOP_BIN;
            end else begin
               // candidate decided
               if (ok_l && ok_r) begin
                  if (kept_ff == KEPT_FULL) begin
                     dropped_in = 1'b1;
                  end else begin
                     pk_we   = 1'b1;
                     kept_in = kept_ff + KEPT_W'(1);
                  end
               end
               if (last_idx) begin
                  bin_vld_in = '0;
                  ptr_in     = '0;
                  state_in   = ST_RD;
               end else begin
                  idx_in   = idx_next;
                  state_in = ST_NBR;
               end
            end
         end

         ST_RD: begin
            state_in = ST_LOAD;
         end

         ST_LOAD: begin
            // fill the output register with one report beat
            rsp_valid_in = 1'b1;
            if (kept_ff == '0) begin
               out_pv_in   = 1'b0;
               out_bin_in  = '0;
               out_cnt_in  = '0;
               out_drop_in = 1'b0;
               out_last_in = 1'b1;
            end else begin
               out_pv_in   = 1'b1;
               out_bin_in  = PIXEL_W'(pk_rd_ff[PE_W-1:COUNT_WIDTH]);
               out_cnt_in  = pk_rd_ff[COUNT_WIDTH-1:0];
               out_drop_in = dropped_ff;
               out_last_in = (KEPT_W'(ptr_ff) + KEPT_W'(1)) == kept_ff;
            end
            state_in = ST_OUT;
         end

         ST_OUT: begin
            if (out_accept) begin
               rsp_valid_in = 1'b0;
               if (out_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in   = ptr_ff + PK_W'(1);
                  state_in = ST_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         radius_ff     <= RADIUS_RESET;
         min_height_ff <= MIN_HEIGHT_RESET;
         kept_ff       <= '0;
         dropped_ff    <= 1'b0;
         bin_vld_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         radius_ff     <= radius_in;
         min_height_ff <= min_height_in;
         kept_ff       <= kept_in;
         dropped_ff    <= dropped_in;
         bin_vld_ff    <= bin_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      dist_ff     <= dist_in;
      cand_ff     <= cand_in;
      ptr_ff      <= ptr_in;
      pix_ff      <= pix_in;
      out_pv_ff   <= out_pv_in;
      out_bin_ff  <= out_bin_in;
      out_cnt_ff  <= out_cnt_in;
      out_drop_ff <= out_drop_in;
      out_last_ff <= out_last_in;
      oob_a_ff    <= oob_a_in;
      oob_b_ff    <= oob_b_in;
      rv_a_ff     <= bin_vld_ff[addr_a];
      rv_b_ff     <= bin_vld_ff[addr_b];
   end

   // histogram memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[pix_ff] <= hist_wd;
      end
      rd_a_ff <= hist_mem[addr_a];
      rd_b_ff <= hist_mem[addr_b];
   end

   // kept peak list
   always_ff @(posedge clock) begin
      if (pk_we) begin
         peak_mem[kept_ff[PK_W-1:0]] <= pk_wd;
      end
      pk_rd_ff <= peak_mem[ptr_ff];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_peak_valid    = out_pv_ff;
   assign rsp_peak_bin      = out_bin_ff;
   assign rsp_peak_count    = out_cnt_ff;
   assign rsp_peaks_dropped = out_drop_ff;
   assign rsp_last          = out_last_ff;

endmodule

// File: test/tb_histogram_peak_finder.sv
// tb_histogram_peak_finder: self-checking bench for the histogram peak finder
// builds images from pixel beats, predicts every peak report and checks it
// depends on hpf_pkg and histogram_peak_finder
`timescale 1ns / 100ps

module tb_histogram_peak_finder;
   import hpf_pkg::*;

   localparam int NB = DEF_NUM_BINS;
   localparam int CW = DEF_COUNT_WIDTH;
   localparam int MP = DEF_MAX_PEAKS;
   localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};
   localparam int QUIET_LIMIT = 100000;
   localparam int SETTLE_CYCLES = 8;

   // radius and height pairs swept by the random images
   localparam int RADIUS_MIX [8] = '{1, 2, 6, 17, 32, 0, 4, 10};
   localparam int HEIGHT_MIX [8] = '{2, 1, 0, 4, 3, 1, 0, 2};

   typedef struct {
      logic               op;
      logic [PIXEL_W-1:0] pixel;
   } hist_beat_type;

   typedef struct {
      logic               hit;
      logic [PIXEL_W-1:0] bin;
      logic [CW-1:0]      count;
      logic               overflow;
      logic               last;
   } peak_report_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_op = OP_PIXEL;
   logic [PIXEL_W-1:0]      req_pixel = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_peak_valid;
   logic [PIXEL_W-1:0]      rsp_peak_bin;
   logic [CW-1:0]           rsp_peak_count;
   logic                    rsp_peaks_dropped;
   logic                    rsp_last;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_WINDOW_RADIUS;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // predictor state: histogram and register copies
   logic [CW-1:0]           bin_model [NB];
   logic [RADIUS_W-1:0]     radius_model = RADIUS_RESET;
   logic [MIN_HEIGHT_W-1:0] height_model = MIN_HEIGHT_RESET;

   hist_beat_type   beats_pending [$];
   peak_report_type peaks_expected [$];

   int req_launched = 0;
   int req_beats = 0;
   int req_idle_pct = 11;
   int rsp_idle_pct = 11;
   int quiet_cycles = 0;
   int mismatches = 0;
   int images = 0;
   int csr_writes = 0;
   int peaks_seen = 0;
   int empties_seen = 0;
   int overflow_reports = 0;

   histogram_peak_finder u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_pixel         (req_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_peak_valid    (rsp_peak_valid),
      .rsp_peak_bin      (rsp_peak_bin),
      .rsp_peak_count    (rsp_peak_count),
      .rsp_peaks_dropped (rsp_peaks_dropped),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      foreach (bin_model[j]) bin_model[j] = '0;
   end

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      if (mismatches < 40)
         $display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // histogram update on a pixel beat, peak scan and clear on a finish beat
   task automatic predict_beat(input hist_beat_type beat);
      int span;
      int run;
      int hits [$];
      bit over;
      logic [CW-1:0] c;
      logic [CW-1:0] left;
      logic [CW-1:0] right;
      peak_report_type rep;
      if (beat.op == OP_PIXEL) begin
         if (bin_model[beat.pixel] != COUNT_MAX) bin_model[beat.pixel] += 1'b1;
         return;
      end
      over = 1'b0;
      span = int'(radius_model);
      for (int i = 1; i <= NB - 2; i++) begin
         c = bin_model[i];
         if (c > bin_model[i-1] && c > bin_model[i+1]) begin
            // walk outward until a taller neighbor shows up
            run = 0;
            for (int d = 1; d <= span; d++) begin
               left = (i - d >= 0) ? bin_model[i-d] : '0;
               right = (i + d < NB) ? bin_model[i+d] : '0;
               if (left > c || right > c) break;
               run++;
            end
            if (run >= span - int'(RUN_SLACK) && c > height_model) begin
               if (hits.size() < MP) hits = {hits, i};
               else over = 1'b1;
            end
         end
      end
      if (hits.size() == 0) begin
         rep.hit = 1'b0;
         rep.bin = '0;
         rep.count = '0;
         rep.overflow = 1'b0;
         rep.last = 1'b1;
         peaks_expected = {peaks_expected, rep};
      end else begin
         foreach (hits[k]) begin
            rep.hit = 1'b1;
            rep.bin = PIXEL_W'(hits[k]);
            rep.count = bin_model[hits[k]];
            rep.overflow = over;
            rep.last = (k == hits.size() - 1);
            peaks_expected = {peaks_expected, rep};
         end
      end
      foreach (bin_model[j]) bin_model[j] = '0;
   endtask

   // driver: next beat or an idle cycle once the current beat is taken
   always @(negedge clock) begin : drive
      hist_beat_type beat;
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beats == req_launched) begin
         if (beats_pending.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
            beat = beats_pending.pop_front();
            req_valid <= 1'b1;
            req_op <= beat.op;
            req_pixel <= beat.pixel;
            req_launched++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: predict on input beats, check result beats, track quiet time
   always @(posedge clock) begin : observe
      peak_report_type due;
      hist_beat_type taken;
      if (rsp_valid && !rsp_stall) begin
         if (peaks_expected.size() == 0) begin
            report_mismatch("unexpected result beat, bin", rsp_peak_bin, 0);
         end else begin
            due = peaks_expected.pop_front();
            if (rsp_peak_valid !== due.hit)
               report_mismatch("peak_valid", rsp_peak_valid, due.hit);
            if (rsp_peak_bin !== due.bin)
               report_mismatch("peak_bin", rsp_peak_bin, due.bin);
            if (rsp_peak_count !== due.count)
               report_mismatch("peak_count", rsp_peak_count, due.count);
            if (rsp_peaks_dropped !== due.overflow)
               report_mismatch("peaks_dropped", rsp_peaks_dropped, due.overflow);
            if (rsp_last !== due.last)
               report_mismatch("last", rsp_last, due.last);
            if (due.hit) peaks_seen++;
            else empties_seen++;
            if (due.last && due.overflow) overflow_reports++;
         end
      end
      if (!reset && req_valid && !req_stall) begin
         taken.op = req_op;
         taken.pixel = req_pixel;
         predict_beat(taken);
         req_beats++;
      end
      if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
   end

   // watchdog
   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("histogram_peak_finder: mismatch");
      $finish;
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (beats_pending.size() != 0 || req_beats != req_launched ||
             peaks_expected.size() != 0);
   endtask

   // one register write; caller lowers valid after the last one
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
      if (idx == CSR_WINDOW_RADIUS) radius_model = data[RADIUS_W-1:0];
      else height_model = data[MIN_HEIGHT_W-1:0];
      csr_writes++;
   endtask

   task automatic set_config(input int radius, input int height);
      logic [CSR_DATA_W-1:0] w;
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      // upper bits above the radius field are junk and must be dropped
      w = CSR_DATA_W'($urandom);
      w[RADIUS_W-1:0] = radius[RADIUS_W-1:0];
      write_csr(CSR_WINDOW_RADIUS, w);
      write_csr(CSR_MIN_PEAK_HEIGHT, CSR_DATA_W'(height));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // pixels of one image followed by its finish beat
   task automatic queue_listed(input int pix [$]);
      hist_beat_type beat;
      foreach (pix[n]) begin
         beat.op = OP_PIXEL;
         beat.pixel = pix[n][PIXEL_W-1:0];
         beats_pending = {beats_pending, beat};
      end
      beat.op = OP_FINISH;
      beat.pixel = PIXEL_W'($urandom);
      beats_pending = {beats_pending, beat};
      images++;
   endtask

   // clustered image with some uniform noise, edges favored now and then
   task automatic queue_image(input int npix, input int nclusters, input int spread);
      int centers [$];
      int pix [$];
      int p;
      repeat (nclusters) begin
         if ($urandom_range(0, 4) == 0)
            p = $urandom_range(0, 1) ? $urandom_range(0, 2)
                                     : $urandom_range(NB - 3, NB - 1);
         else
            p = $urandom_range(0, NB - 1);
         centers = {centers, p};
      end
      repeat (npix) begin
         if ($urandom_range(0, 9) == 0)
            p = $urandom_range(0, NB - 1);
         else
            p = centers[$urandom_range(0, nclusters - 1)] + int'($urandom_range(0, spread))
                - int'($urandom_range(0, spread));
         if (p < 0) p = 0;
         if (p > NB - 1) p = NB - 1;
         pix = {pix, p};
      end
      queue_listed(pix);
   endtask

   // comb of isolated odd bins, each a peak, to fill the report
   task automatic queue_comb(input int npeaks);
      int pix [$];
      int need;
      int avail;
      need = npeaks;
      avail = (NB - 2) / 2;
      for (int b = 1; b <= NB - 3; b += 2) begin
         if ($urandom_range(1, avail) <= need) begin
            pix = {pix, b};
            need--;
         end
         avail--;
      end
      queue_listed(pix);
   endtask

   initial begin : stimulus
      int none [$];
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: empty histogram, then extremes that stay below height
      queue_listed(none);
      queue_listed('{0, 255, 85, 170});

      // zero radius, zero height: edge bins and a scan-excluded top bin
      set_config(0, 0);
      queue_listed('{1, 1, 254, 255, 255, 255, 128});

      // widest radius: out-of-range neighbors, a plateau, a blocked run
      set_config(63, 0);
      queue_listed('{5, 5, 5, 100, 100, 101, 101, 200, 210, 210});

      // default radius with a low height so a short image qualifies
      set_config(10, 2);
      queue_image(10, 2, 0);

      // random images over a sweep of settings, draining mid-phase
      for (int s = 0; s < 8; s++) begin
         set_config(RADIUS_MIX[s], HEIGHT_MIX[s]);
         for (int m = 0; m < 2; m++) begin
            queue_image($urandom_range(2, 7), $urandom_range(1, 4), $urandom_range(0, 3));
            if (m == 0) wait_drained();
         end
      end

      // overflowing report, no idling on either side
      set_config(3, 0);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      queue_comb(MP + 1);
      wait_drained();
      req_idle_pct = 11;
      rsp_idle_pct = 11;

      // height at its top: nothing can qualify
      set_config(5, (1 << MIN_HEIGHT_W) - 1);
      queue_image(6, 2, 0);
      queue_image(4, 1, 1);

      wait_drained();
      repeat (20) @(negedge clock);
      if (peaks_expected.size() != 0)
         report_mismatch("results never delivered", 0, peaks_expected.size());
      $display("covered %0d images, %0d input beats, %0d register writes",
               images, req_beats, csr_writes);
      $display("%0d peaks, %0d empty reports, %0d reports past the peak limit",
               peaks_seen, empties_seen, overflow_reports);
      if (mismatches == 0) begin
         $display("histogram_peak_finder: match");
      end else begin
         $display("histogram_peak_finder: mismatch");
      end
      $finish;
   end

endmodule
